[sv/pmc_pkg.sv]
// shared types and constants for the pid motor controller
// no dependencies; imported by every module of the block
`default_nettype none

package pmc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RATE_HZ   = 100;

  // derivative operand is measurement change times twice the loop rate
  localparam int DIF_SCALE   = 2 * RATE_HZ;
  localparam int DIF_SCALE_W = $clog2(DIF_SCALE + 1) + 1;

  localparam int VAL_W     = 32;
  localparam int ERR_W     = VAL_W + 1;
  localparam int ES_W      = 48;
  localparam int DOP_W     = ERR_W + DIF_SCALE_W;
  localparam int OP_W      = 64;
  localparam int DIG_W     = 32;
  localparam int MUL_W     = DIG_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 84;
  localparam int ACC_SHIFT = 2 * FRAC_BITS + 1;
  localparam int MAG_W     = 31;
  localparam int PD_W      = 33;
  localparam int DRV_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [1:0] MODE_PID  = 2'd0;
  localparam logic [1:0] MODE_RAMP = 2'd1;
  localparam logic [1:0] MODE_FF   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_DEAD_OFFSET = 3'd4,
    REG_DRIVE_LIMIT = 3'd5,
    REG_RAMP_BAND   = 3'd6,
    REG_RAMP_STEP   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [1:0]       mode;
    logic signed [VAL_W-1:0] gain_p;
    logic signed [VAL_W-1:0] gain_i;
    logic signed [VAL_W-1:0] gain_d;
    logic        [7:0]       dead_offset;
    logic        [14:0]      drive_limit;
    logic        [30:0]      ramp_band;
    logic        [7:0]       ramp_step;
  } pmc_cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] goal_value;
    logic signed [VAL_W-1:0] measured_value;
    logic                    stop_press;
  } pmc_in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive_out;
    logic                    stopped;
    logic                    clamped;
  } pmc_out_t;

  // request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                    clr;
    logic                    go;
    logic                    hi;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } pmc_mac_req_t;

endpackage

`default_nettype wire

[sv/pmc_cfg_regs.sv]
// configuration register file of the pid motor controller
// depends on pmc_pkg
`default_nettype none

module pmc_cfg_regs (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [pmc_pkg::CFG_DAT_W-1:0] cfg_data,
  output pmc_pkg::pmc_cfg_t             cfg
);
  import pmc_pkg::*;

  pmc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_PID;
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.dead_offset <= 8'd10;
      cfg_r.drive_limit <= 15'd255;
      cfg_r.ramp_band   <= 31'd65536;
      cfg_r.ramp_step   <= 8'd5;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:        cfg_r.mode        <= cfg_data[1:0];
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_data;
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_data;
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_data;
        REG_DEAD_OFFSET: cfg_r.dead_offset <= cfg_data[7:0];
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_data[14:0];
        REG_RAMP_BAND:   cfg_r.ramp_band   <= cfg_data[30:0];
        REG_RAMP_STEP:   cfg_r.ramp_step   <= cfg_data[7:0];
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/pmc_mac.sv]
// shared 33x33 signed multiplier with registered product and wide accumulator
// depends on pmc_pkg
`default_nettype none

module pmc_mac (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  pmc_pkg::pmc_mac_req_t               req,
  output logic signed [pmc_pkg::ACC_W-1:0]    acc
);
  import pmc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_hi_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  addend;

  // high digit products weigh 2^32
  always_comb begin
    addend = ACC_W'(prod_r);
    if (prod_hi_r) begin
      addend = addend <<< DIG_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= req.go & ~req.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r    <= req.a * req.b;
      prod_hi_r <= req.hi;
    end
    if (req.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

[sv/pmc_seq.sv]
// control tick sequencer: mode decode, pid state, ramp, offset and clamp
// depends on pmc_pkg; drives the shared pmc_mac unit
`default_nettype none

module pmc_seq (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  pmc_pkg::pmc_in_t                  in_data,
  input  pmc_pkg::pmc_cfg_t                 cfg,
  input  wire                               out_free,
  output logic                              res_valid,
  output pmc_pkg::pmc_out_t                 res,
  output pmc_pkg::pmc_mac_req_t             mac_req,
  input  wire signed [pmc_pkg::ACC_W-1:0]   acc
);
  import pmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ABS,
    S_OFS,
    S_DONE
  } state_t;

  localparam logic [2:0] MUL_LAST = 3'd6;
  localparam logic [2:0] MUL_ISSUES = 3'd6;

  localparam logic signed [ES_W+1:0] ES_HI = {3'b000, {(ES_W-1){1'b1}}};
  localparam logic signed [ES_W+1:0] ES_LO = -ES_HI;
  localparam logic signed [VAL_W-1:0] V_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] V_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [DOP_W-1:0] DIF_K = DOP_W'(DIF_SCALE);
  localparam logic signed [ES_W-1:0] ES_BAD = {1'b1, {(ES_W-1){1'b0}}};

  state_t                   state_r;
  logic signed [VAL_W-1:0]  goal_r;
  logic signed [VAL_W-1:0]  meas_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     stop_latch_r;
  logic signed [ES_W-1:0]   error_sum_r;
  logic signed [VAL_W-1:0]  last_error_r;
  logic signed [VAL_W-1:0]  last_meas_r;
  logic signed [DRV_W-1:0]  ramp_drive_r;
  logic signed [DOP_W-1:0]  d_op_r;
  logic [2:0]               cnt_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         mag_r;
  logic signed [PD_W-1:0]   pre_drive_r;

  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [VAL_W-1:0]  e32;
  logic signed [ES_W+1:0]   es_wide;
  logic signed [ES_W-1:0]   error_sum_nxt;
  logic signed [ERR_W-1:0]  meas_dif;
  logic signed [DOP_W-1:0]  d_op_nxt;
  logic signed [ERR_W:0]    err2;
  logic signed [OP_W-1:0]   op;
  logic signed [VAL_W-1:0]  gain;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         acc_sh;
  logic [MAG_W-1:0]         mag_nxt;
  logic [VAL_W-1:0]         goal_mag;
  logic [MAG_W-1:0]         ff_mag;
  logic signed [PD_W-1:0]   band_s;
  logic signed [PD_W-1:0]   step_s;
  logic signed [PD_W-1:0]   lim_s;
  logic signed [PD_W-1:0]   ramp_nxt;
  logic signed [PD_W-1:0]   ff_nxt;
  logic signed [PD_W-1:0]   drive_nxt;
  logic                     clip_nxt;
  logic signed [DRV_W-1:0]  lim16;

  // adds the deadband offset in the direction of the sign, zero stays zero
  function automatic logic signed [PD_W-1:0] with_offset(
    input logic             neg,
    input logic [MAG_W-1:0] m,
    input logic [7:0]       off
  );
    logic signed [PD_W-1:0] s;
    s = PD_W'(m) + PD_W'(off);
    if (m == '0) begin
      return '0;
    end
    return neg ? -s : s;
  endfunction

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    err_nxt = ERR_W'(in_data.goal_value) - ERR_W'(in_data.measured_value);

    // trapezoid and last_error use the error saturated to 32 bits
    if (err_r[ERR_W-1] != err_r[ERR_W-2]) begin
      e32 = err_r[ERR_W-1] ? V_MIN : V_MAX;
    end else begin
      e32 = err_r[VAL_W-1:0];
    end
    es_wide = (ES_W+2)'(error_sum_r) + (ES_W+2)'(e32) + (ES_W+2)'(last_error_r);
    if (es_wide > ES_HI) begin
      error_sum_nxt = ES_W'(ES_HI);
    end else if (es_wide < ES_LO) begin
      error_sum_nxt = ES_W'(ES_LO);
    end else begin
      error_sum_nxt = es_wide[ES_W-1:0];
    end

    // subtracted derivative term: operand is (last - meas) * 2 * rate
    meas_dif = ERR_W'(last_meas_r) - ERR_W'(meas_r);
    d_op_nxt = DOP_W'(meas_dif) * DIF_K;

    // operand and gain for the current partial product
    err2 = {err_r, 1'b0};
    unique case (cnt_r[2:1])
      2'd0: begin
        op   = OP_W'(err2);
        gain = cfg.gain_p;
      end
      2'd1: begin
        op   = OP_W'(error_sum_r);
        gain = cfg.gain_i;
      end
      2'd2: begin
        op   = OP_W'(d_op_r);
        gain = cfg.gain_d;
      end
      default: begin
        op   = '0;
        gain = '0;
      end
    endcase
    mac_req.clr = (state_r == S_PREP);
    mac_req.go  = (state_r == S_MUL) && (cnt_r < MUL_ISSUES);
    mac_req.hi  = cnt_r[0];
    mac_req.a   = MUL_W'(gain);
    mac_req.b   = cnt_r[0] ? {op[OP_W-1], op[OP_W-1:DIG_W]} : {1'b0, op[DIG_W-1:0]};

    // truncate toward zero, saturate the magnitude at 2^31-1
    acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    acc_sh  = acc_mag >> ACC_SHIFT;
    mag_nxt = (|acc_sh[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : acc_sh[MAG_W-1:0];

    goal_mag = goal_r[VAL_W-1] ? VAL_W'(-goal_r) : VAL_W'(goal_r);
    ff_mag   = MAG_W'(goal_mag >> FRAC_BITS);
    ff_nxt   = with_offset(goal_r[VAL_W-1], ff_mag, cfg.dead_offset);

    band_s = PD_W'(cfg.ramp_band);
    step_s = PD_W'(cfg.ramp_step);
    lim_s  = PD_W'(cfg.drive_limit);
    ramp_nxt = PD_W'(ramp_drive_r);
    if (PD_W'(err_r) > band_s) begin
      ramp_nxt = ramp_nxt + step_s;
    end else if (PD_W'(err_r) < -band_s) begin
      ramp_nxt = ramp_nxt - step_s;
    end

    drive_nxt = pre_drive_r;
    clip_nxt  = 1'b0;
    if (pre_drive_r > lim_s) begin
      drive_nxt = lim_s;
      clip_nxt  = 1'b1;
    end else if (pre_drive_r < -lim_s) begin
      drive_nxt = -lim_s;
      clip_nxt  = 1'b1;
    end

    res_valid     = (state_r == S_DONE) && out_free;
    res.drive_out = stop_latch_r ? '0 : drive_nxt[DRV_W-1:0];
    res.stopped   = stop_latch_r;
    res.clamped   = clip_nxt & ~stop_latch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stop_latch_r <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
      last_meas_r  <= '0;
      ramp_drive_r <= '0;
      cnt_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            goal_r       <= in_data.goal_value;
            meas_r       <= in_data.measured_value;
            err_r        <= err_nxt;
            stop_latch_r <= stop_latch_r ^ in_data.stop_press;
            state_r      <= S_PREP;
          end
        end
        S_PREP: begin
          unique case (cfg.mode)
            MODE_PID: begin
              error_sum_r  <= error_sum_nxt;
              last_error_r <= e32;
              last_meas_r  <= meas_r;
              d_op_r       <= d_op_nxt;
              cnt_r        <= '0;
              state_r      <= S_MUL;
            end
            MODE_RAMP: begin
              pre_drive_r <= ramp_nxt;
              state_r     <= S_DONE;
            end
            default: begin
              pre_drive_r <= ff_nxt;
              state_r     <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == MUL_LAST) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          neg_r   <= acc[ACC_W-1];
          mag_r   <= mag_nxt;
          state_r <= S_OFS;
        end
        S_OFS: begin
          pre_drive_r <= with_offset(neg_r, mag_r, cfg.dead_offset);
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            ramp_drive_r <= drive_nxt[DRV_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign lim16 = DRV_W'(cfg.drive_limit);

  // integral saturation is symmetric, the most negative code never appears
  a_sum_sym: assert property (@(posedge clk) disable iff (!rst_n)
    error_sum_r != ES_BAD)
    else $error("error_sum reached the asymmetric minimum");

  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("result issued while the sequencer takes input");

  a_clip_run: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.clamped) |-> !res.stopped)
    else $error("clamped flagged while stopped");

  a_drive_lim: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.drive_out <= lim16) && (res.drive_out >= -lim16))
    else $error("drive outside the limit");

  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == MUL_LAST) |=> state_r == S_ABS)
    else $error("multiply sequence did not end in the magnitude step");

endmodule

`default_nettype wire

[sv/pid_motor_controller_top.sv]
// pid motor controller: config registers, tick sequencer, shared mac, result register
// depends on pmc_pkg, pmc_cfg_regs, pmc_mac, pmc_seq
//
// use: write registers through the cfg channel (index 0..7) while the block is idle;
// cfg_ready is always high. Each transfer on the in channel is one control tick
// (goal, measurement, stop press) and yields exactly one transfer on the out channel.
// After the input transfer a tick passes the prep and done states in ramp and
// feedforward modes, and prep, mul, abs, ofs and done in pid mode; its result then
// enters the output register. in_ready is low while a tick is in work, so a new tick
// is taken only once the last has left the sequencer. In pid mode the six 33x33
// partial products pass one at a time through the single registered multiplier and
// the accumulator behind it. The result sits in an output register: the next tick
// is taken while it waits, and that tick finishes only once the register is free,
// so a stalled receiver holds the block after one further tick.
// Reset (synchronous, active low) loads register defaults, clears the integral,
// last error, last measurement, ramp drive and the stop latch, and empties the
// output register.
`default_nettype none

module pid_motor_controller_top (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [pmc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  pmc_pkg::pmc_in_t              in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output pmc_pkg::pmc_out_t             out_data
);
  import pmc_pkg::*;

  pmc_cfg_t                cfg;
  pmc_mac_req_t            mac_req;
  logic signed [ACC_W-1:0] acc;
  logic                    res_valid;
  pmc_out_t                res;
  logic                    out_valid_r;
  pmc_out_t                out_data_r;
  logic                    out_free;

  pmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .acc   (acc)
  );

  pmc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mac_req   (mac_req),
    .acc       (acc)
  );

  // slot is free when empty or its transfer completes this cycle
  assign out_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
